FILE: rtl/mpfb_pkg.sv
// Shared types and codes for the page-addressed monochrome framebuffer.
// No dependencies; imported by every other file of the block.
`default_nettype none

package mpfb_pkg;

    // Request kinds carried on s_tuser
    localparam logic [2:0] REQ_PIXEL = 3'd0;
    localparam logic [2:0] REQ_RECT  = 3'd1;
    localparam logic [2:0] REQ_CLRREG = 3'd2;
    localparam logic [2:0] REQ_CLRALL = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // Input field widths (fixed by the bus format)
    localparam int REQ_W  = 3;
    localparam int X_W    = 7;
    localparam int Y_W    = 6;
    localparam int LEN_W  = 8;
    localparam int PG_IN_W = 3;
    localparam int BYTE_W = 8;
    localparam int TDATA_W = 48;

    // Store access kinds
    typedef enum logic [1:0] {
        OP_READ = 2'd0,
        OP_SET  = 2'd1,
        OP_CLR  = 2'd2,
        OP_ZERO = 2'd3
    } op_t;

    // One store access from the sequencer
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [BYTE_W-1:0] mask;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/mpfb_store.sv
// Frame store: synchronous RAM plus a read-modify-write stage.
// Depends on mpfb_pkg (cmd_t, op_t).
`default_nettype none

module mpfb_store import mpfb_pkg::*; #(
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd_i,
    input  wire logic [ADDR_W-1:0] addr_i,
    output logic      [BYTE_W-1:0] rdata_o
);

    logic [BYTE_W-1:0] store_mem [DEPTH];

    logic [BYTE_W-1:0] rd_reg;
    logic              stg_valid_reg;
    op_t               stg_op_reg;
    logic [BYTE_W-1:0] stg_mask_reg;
    logic [ADDR_W-1:0] stg_addr_reg;

    logic              wr_en;
    logic [BYTE_W-1:0] wr_data;

    // read port
    always_ff @(posedge clk) begin
        if (cmd_i.valid) begin
            rd_reg <= store_mem[addr_i];
        end
    end

    // write port, writes in the cycle after the read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            store_mem[stg_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= cmd_i.valid;
        end
        stg_op_reg   <= cmd_i.op;
        stg_mask_reg <= cmd_i.mask;
        stg_addr_reg <= addr_i;
    end

    always_comb begin
        wr_en = stg_valid_reg && (stg_op_reg != OP_READ);
        unique case (stg_op_reg)
            OP_SET:  wr_data = rd_reg | stg_mask_reg;
            OP_CLR:  wr_data = rd_reg & ~stg_mask_reg;
            OP_ZERO: wr_data = '0;
            default: wr_data = rd_reg;
        endcase
    end

    assign rdata_o = rd_reg;

endmodule

`default_nettype wire

FILE: rtl/mpfb_seq.sv
// Request decoder and address sequencer: clips requests, walks page/column
// bytes, drives the store and holds the result register. Uses mpfb_pkg.
`default_nettype none

module mpfb_seq import mpfb_pkg::*; #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8,
    localparam int DEPTH  = COLUMNS * PAGES,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [REQ_W-1:0]   req_type,
    input  wire logic [X_W-1:0]     x,
    input  wire logic [Y_W-1:0]     y,
    input  wire logic [LEN_W-1:0]   width,
    input  wire logic [LEN_W-1:0]   height,
    input  wire logic               pixel_on,
    input  wire logic [X_W-1:0]     col_end,
    input  wire logic [PG_IN_W-1:0] page_start,
    input  wire logic [PG_IN_W-1:0] page_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [BYTE_W-1:0]       read_data,
    output cmd_t                    cmd_o,
    output logic [ADDR_W-1:0]       addr_o,
    input  wire logic [BYTE_W-1:0]  rdata_i
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int PG_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ROWS  = PAGES * 8;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WALK  = 2'd1,
        ST_DRAIN = 2'd2
    } state_t;

    state_t            state_reg;
    op_t               op_reg;
    logic [COL_W-1:0]  c0_reg, c1_reg, col_reg;
    logic [PG_W-1:0]   p0_reg, p1_reg, page_reg;
    logic [2:0]        lo_reg, hi_reg;
    logic              rd_flag_reg;
    logic              resp_reg;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_data_reg;

    // decode of the request on the input port
    logic [LEN_W-1:0] w_eff, h_eff;
    logic [8:0]       xe, xe_clip, xlast, ye, ye_clip, ylast, ce_sat;
    logic [4:0]       pe_sat;
    logic             rect_empty, region_empty, read_ok;
    op_t              d_op;
    logic [COL_W-1:0] d_c0, d_c1;
    logic [PG_W-1:0]  d_p0, d_p1;
    logic [2:0]       d_lo, d_hi;
    logic             d_walk, d_rd;

    // walk datapath
    logic [2:0]        m_lo, m_hi;
    logic [BYTE_W-1:0] mask;

    always_comb begin
        w_eff   = (req_type == REQ_PIXEL) ? 8'd1 : width;
        h_eff   = (req_type == REQ_PIXEL) ? 8'd1 : height;
        xe      = {2'b00, x} + {1'b0, w_eff};
        xe_clip = (xe > 9'(COLUMNS)) ? 9'(COLUMNS) : xe;
        xlast   = xe_clip - 9'd1;
        ye      = {3'b000, y} + {1'b0, h_eff};
        ye_clip = (ye > 9'(ROWS)) ? 9'(ROWS) : ye;
        ylast   = ye_clip - 9'd1;
        rect_empty = (w_eff == '0) || ({2'b00, x} >= 9'(COLUMNS))
                     || (ye_clip <= {3'b000, y});

        ce_sat = ({2'b00, col_end} >= 9'(COLUMNS)) ? 9'(COLUMNS - 1) : {2'b00, col_end};
        pe_sat = ({2'b00, page_end} >= 5'(PAGES)) ? 5'(PAGES - 1) : {2'b00, page_end};
        region_empty = ({2'b00, page_start} > pe_sat) || ({2'b00, x} > ce_sat);

        read_ok = ({2'b00, x} < 9'(COLUMNS)) && ({2'b00, page_start} < 5'(PAGES));

        d_op   = OP_READ;
        d_c0   = COL_W'(x);
        d_c1   = COL_W'(x);
        d_p0   = PG_W'(page_start);
        d_p1   = PG_W'(page_start);
        d_lo   = 3'd0;
        d_hi   = 3'd7;
        d_walk = 1'b0;
        d_rd   = 1'b0;

        unique case (req_type)
            REQ_PIXEL, REQ_RECT: begin
                d_op   = pixel_on ? OP_SET : OP_CLR;
                d_c1   = COL_W'(xlast);
                d_p0   = PG_W'(y[5:3]);
                d_p1   = PG_W'(ylast[8:3]);
                d_lo   = y[2:0];
                d_hi   = ylast[2:0];
                d_walk = !rect_empty;
            end
            REQ_CLRREG: begin
                d_op   = OP_ZERO;
                d_c1   = COL_W'(ce_sat);
                d_p1   = PG_W'(pe_sat);
                d_walk = !region_empty;
            end
            REQ_CLRALL: begin
                d_op   = OP_ZERO;
                d_c0   = '0;
                d_c1   = COL_W'(COLUMNS - 1);
                d_p0   = '0;
                d_p1   = PG_W'(PAGES - 1);
                d_walk = 1'b1;
            end
            REQ_READ: begin
                d_walk = read_ok;
                d_rd   = read_ok;
            end
            default: begin
                d_walk = 1'b0;
            end
        endcase
    end

    // row mask for the current page; only the first and last pages are partial
    always_comb begin
        m_lo = (page_reg == p0_reg) ? lo_reg : 3'd0;
        m_hi = (page_reg == p1_reg) ? hi_reg : 3'd7;
        mask = (8'hFF << m_lo) & (8'hFF >> (3'd7 - m_hi));
    end

    assign cmd_o.valid = (state_reg == ST_WALK);
    assign cmd_o.op    = op_reg;
    assign cmd_o.mask  = mask;
    assign addr_o      = ADDR_W'(page_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            // power-up clearing pass over the whole store, no result
            state_reg   <= ST_WALK;
            op_reg      <= OP_ZERO;
            c0_reg      <= '0;
            c1_reg      <= COL_W'(COLUMNS - 1);
            p0_reg      <= '0;
            p1_reg      <= PG_W'(PAGES - 1);
            col_reg     <= '0;
            page_reg    <= '0;
            lo_reg      <= 3'd0;
            hi_reg      <= 3'd7;
            rd_flag_reg <= 1'b0;
            resp_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end else begin
            // taken result drops, unless the drain state loads the next one
            if (m_ready && !(state_reg == ST_DRAIN && resp_reg)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg      <= d_op;
                        c0_reg      <= d_c0;
                        c1_reg      <= d_c1;
                        p0_reg      <= d_p0;
                        p1_reg      <= d_p1;
                        col_reg     <= d_c0;
                        page_reg    <= d_p0;
                        lo_reg      <= d_lo;
                        hi_reg      <= d_hi;
                        rd_flag_reg <= d_rd;
                        resp_reg    <= 1'b1;
                        state_reg   <= d_walk ? ST_WALK : ST_DRAIN;
                    end
                end
                ST_WALK: begin
                    if (col_reg == c1_reg) begin
                        col_reg <= c0_reg;
                        if (page_reg == p1_reg) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            page_reg <= page_reg + PG_W'(1);
                        end
                    end else begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
                ST_DRAIN: begin
                    // the last write of a walk lands in the first drain cycle; read byte is in rdata_i
                    if (!resp_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= rd_flag_reg ? rdata_i : '0;
                        resp_reg    <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign read_data = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/mono_page_framebuffer_draw.sv
// Page-addressed monochrome framebuffer, COLUMNS x PAGES*8 pixels.
// A request that touches no byte skips the walk and goes to the result stage;
//   others first walk the column bytes they touch (pixel and read: one).
// Requests are taken one at a time; the sequencer walks one byte per cycle
//   through a read-modify-write on the single store port pair.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the
//   store while s_tready stays low. Uses mpfb_pkg.
`default_nettype none

module mono_page_framebuffer_draw import mpfb_pkg::*; #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // request channel
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [REQ_W-1:0]    s_tuser,   // req_type
    // x[6:0], y[12:7], width[20:13], height[28:21], pixel_on[29],
    // col_end[36:30], page_start[39:37], page_end[42:40], zero fill above
    input  wire logic [TDATA_W-1:0]  s_tdata,
    // result channel
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [BYTE_W-1:0]        m_tdata    // read_data[7:0]
);

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);

    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] rdata;

    // Sequencer: decodes and clips the request on accept, then issues one
    // store access per cycle. A rectangle's row mask is narrowed only on its
    // first and last page. Result register decouples the output side.
    mpfb_seq #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_seq (
        .clk        (aclk),
        .rst_n      (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .req_type   (s_tuser),
        .x          (s_tdata[6:0]),
        .y          (s_tdata[12:7]),
        .width      (s_tdata[20:13]),
        .height     (s_tdata[28:21]),
        .pixel_on   (s_tdata[29]),
        .col_end    (s_tdata[36:30]),
        .page_start (s_tdata[39:37]),
        .page_end   (s_tdata[42:40]),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .read_data  (m_tdata),
        .cmd_o      (cmd),
        .addr_o     (addr),
        .rdata_i    (rdata)
    );

    // Store: reads a byte, then writes back the modified byte the next cycle.
    // Addresses within one walk never repeat and the sequencer passes through
    // its drain state between items, so no forwarding is needed.
    mpfb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (aclk),
        .rst_n   (aresetn),
        .cmd_i   (cmd),
        .addr_i  (addr),
        .rdata_o (rdata)
    );

endmodule

`default_nettype wire

FILE: rtl/mpfb_checker.sv
// Port-level checks for the framebuffer top level, with its bind.
// Depends on mpfb_pkg and mono_page_framebuffer_draw.
`default_nettype none

module mpfb_checker import mpfb_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [BYTE_W-1:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // reset starts the clearing pass: no input taken, no result shown
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("block active right after reset");

    // one item at a time: an accepted beat closes the input
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input stayed open after accept");

    // a new result only comes out of a busy cycle
    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

endmodule

bind mono_page_framebuffer_draw mpfb_checker u_mpfb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
